/* rtl/core/dual_sine_trajectory_diff_mixer_core_defines.svh */
// Assertion macros for the dual sine trajectory mixer core.
// Clocked on clk_i, disabled while rst_ni is low; no other dependencies.
`ifndef DUAL_SINE_TRAJECTORY_DIFF_MIXER_CORE_DEFINES_SVH
`define DUAL_SINE_TRAJECTORY_DIFF_MIXER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DSTDM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dstdm assertion failed");
`define DSTDM_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("dstdm forbidden condition seen");
`else
`define DSTDM_ASSERT(lbl, prop)
`define DSTDM_NEVER(lbl, expr)
`endif

`endif

/* rtl/core/dstdm_pkg.sv */
// Shared types, constants and the quarter-wave sine generator function.
// Used by every module of the dual sine trajectory mixer core.
package dstdm_pkg;

  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned QUARTER_N = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned SINE_W = 15;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned FREQ_W = 24;
  localparam int unsigned OFFS_W = 16;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned TGT_W = 17;
  localparam int unsigned MOTOR_W = 22;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [FREQ_W-1:0] DRIVE_FREQ_RST = 24'd8192;
  localparam logic [FREQ_W-1:0] STEER_FREQ_RST = 24'd16384;
  localparam logic [OFFS_W-1:0] STEER_OFFS_RST = 16'd8192;
  localparam logic [GAIN_W-1:0] DRIVE_AMP_RST = 16'd19302;
  localparam logic [GAIN_W-1:0] STEER_AMP_RST = 16'd12868;
  localparam logic [GAIN_W-1:0] DRIVE_GEAR_RST = 16'd4415;
  localparam logic [GAIN_W-1:0] STEER_GEAR_RST = 16'd2560;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_FREQ = 3'd0,
    REG_STEER_FREQ = 3'd1,
    REG_STEER_OFFS = 3'd2,
    REG_DRIVE_AMP  = 3'd3,
    REG_STEER_AMP  = 3'd4,
    REG_DRIVE_GEAR = 3'd5,
    REG_STEER_GEAR = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DF,
    ST_SF,
    ST_SD,
    ST_SS,
    ST_TD,
    ST_TS,
    ST_PD,
    ST_MIX
  } state_e;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              neg;
    logic [SINE_W-1:0] mag;
  } sine_t;

  // Q1.14 sine of entry k of the quarter wave, Taylor series in Q2.30
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30) / QUARTER_N;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = (unsigned'(sum) + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

/* rtl/core/dstdm_mul.sv */
// Shared signed multiplier with registered product.
// Depends on dstdm_pkg for operand and product widths.
module dstdm_mul (
  input  logic                                   clk_i,
  input  dstdm_pkg::mul_req_t                    req_i,
  output logic signed [dstdm_pkg::MUL_P_W-1:0]   prod_o
);

  logic signed [dstdm_pkg::MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= dstdm_pkg::MUL_P_W'(req_i.a) * dstdm_pkg::MUL_P_W'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/dstdm_sine_rom.sv */
// Quarter-wave sine table with quadrant folding and registered output.
// Depends on dstdm_pkg for the table generator and the sine_t type.
module dstdm_sine_rom (
  input  logic                              clk_i,
  input  logic [dstdm_pkg::PHASE_W-1:0]     phase_i,
  output dstdm_pkg::sine_t                  sine_o
);

  localparam int unsigned B = dstdm_pkg::SINE_TABLE_BITS;

  logic [dstdm_pkg::SINE_W-1:0] lut [dstdm_pkg::QUARTER_N+1];
  logic [B-1:0]                 idx;
  logic [1:0]                   quad;
  logic [B-3:0]                 j;
  logic [B-2:0]                 addr;
  dstdm_pkg::sine_t             sine_q;

  for (genvar k = 0; k <= dstdm_pkg::QUARTER_N; k++) begin : g_lut
    assign lut[k] = dstdm_pkg::sine_entry(k);
  end

  assign idx  = phase_i[dstdm_pkg::PHASE_W-1 -: B];
  assign quad = idx[B-1:B-2];
  assign j    = idx[B-3:0];
  assign addr = quad[0] ? ((B-1)'(dstdm_pkg::QUARTER_N) - {1'b0, j}) : {1'b0, j};

  always_ff @(posedge clk_i) begin
    sine_q.mag <= lut[addr];
    sine_q.neg <= quad[1];
  end

  assign sine_o = sine_q;

endmodule

/* rtl/core/dual_sine_trajectory_diff_mixer_core.sv */
// Top level: sequencer, phase accumulators, registers and output stage.
// Depends on dstdm_pkg, dstdm_mul, dstdm_sine_rom and the defines header.
//
// channel | direction | signals
// in      | sink      | in_valid_i, in_ready_o, time_step_i
// out     | source    | out_valid_o, out_ready_i, drive_target_o, steer_target_o,
//         |           | motor0_position_o, motor1_position_o
// cfg     | sink      | cfg_wr_en_i, cfg_index_i, cfg_data_i
//
// Each accepted word runs through eight sequencer steps around the one shared
// multiplier before the next word can be accepted.
// in_ready_o is high only in the idle state.
// A waiting result stalls the final mixing step until out_ready_i is high.
// Reset clears the phases and loads the register defaults.
module dual_sine_trajectory_diff_mixer_core (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic [dstdm_pkg::STEP_W-1:0]                 time_step_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic signed [dstdm_pkg::TGT_W-1:0]           drive_target_o,
  output logic signed [dstdm_pkg::TGT_W-1:0]           steer_target_o,
  output logic signed [dstdm_pkg::MOTOR_W-1:0]         motor0_position_o,
  output logic signed [dstdm_pkg::MOTOR_W-1:0]         motor1_position_o,
  input  logic                                         cfg_wr_en_i,
  input  logic [dstdm_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [dstdm_pkg::CFG_DATA_W-1:0]             cfg_data_i
);

`include "dual_sine_trajectory_diff_mixer_core_defines.svh"

  localparam int unsigned PW = dstdm_pkg::PHASE_W;
  localparam int unsigned TW = dstdm_pkg::TGT_W;
  localparam int unsigned GW = dstdm_pkg::GAIN_W;
  localparam int unsigned PDW = TW + GW;
  localparam int unsigned SUMW = PDW + 2;

  dstdm_pkg::state_e state_q, state_d;

  logic [dstdm_pkg::FREQ_W-1:0] drive_freq_q, steer_freq_q;
  logic [dstdm_pkg::OFFS_W-1:0] steer_offs_q;
  logic [GW-1:0]                drive_amp_q, steer_amp_q, drive_gear_q, steer_gear_q;

  logic [dstdm_pkg::STEP_W-1:0]       dt_q;
  logic [PW-1:0]                      dphase_q, sphase_q;
  logic                               dneg_q;
  logic signed [TW-1:0]               td_q, ts_q;
  logic signed [PDW-1:0]              pd_q;
  logic                               out_valid_q;
  logic signed [TW-1:0]               drive_tgt_q, steer_tgt_q;
  logic signed [dstdm_pkg::MOTOR_W-1:0] m0_q, m1_q;

  dstdm_pkg::mul_req_t                   mul_req;
  logic signed [dstdm_pkg::MUL_P_W-1:0]  prod;
  logic [PW-1:0]                         rom_phase;
  dstdm_pkg::sine_t                      sine;

  logic                 in_acc;
  logic                 out_load;
  logic [29:0]          rnd_sum;
  logic [15:0]          tgt_mag;
  logic signed [TW-1:0] tgt_pos;
  logic signed [SUMW-1:0] mix_sum, mix_dif;

  dstdm_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  dstdm_sine_rom u_rom (
    .clk_i   (clk_i),
    .phase_i (rom_phase),
    .sine_o  (sine)
  );

  assign in_ready_o = (state_q == dstdm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == dstdm_pkg::ST_MIX) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dstdm_pkg::ST_IDLE: if (in_valid_i) state_d = dstdm_pkg::ST_DF;
      dstdm_pkg::ST_DF:   state_d = dstdm_pkg::ST_SF;
      dstdm_pkg::ST_SF:   state_d = dstdm_pkg::ST_SD;
      dstdm_pkg::ST_SD:   state_d = dstdm_pkg::ST_SS;
      dstdm_pkg::ST_SS:   state_d = dstdm_pkg::ST_TD;
      dstdm_pkg::ST_TD:   state_d = dstdm_pkg::ST_TS;
      dstdm_pkg::ST_TS:   state_d = dstdm_pkg::ST_PD;
      dstdm_pkg::ST_PD:   state_d = dstdm_pkg::ST_MIX;
      dstdm_pkg::ST_MIX:  if (out_load) state_d = dstdm_pkg::ST_IDLE;
      default:            state_d = dstdm_pkg::ST_IDLE;
    endcase
  end

  // multiplier operands and table phase
  always_comb begin
    mul_req   = '0;
    rom_phase = dphase_q;
    unique case (state_q)
      dstdm_pkg::ST_DF: begin
        mul_req.a = {1'b0, drive_freq_q};
        mul_req.b = {1'b0, dt_q};
      end
      dstdm_pkg::ST_SF: begin
        mul_req.a = {1'b0, steer_freq_q};
        mul_req.b = {1'b0, dt_q};
      end
      dstdm_pkg::ST_SS: begin
        rom_phase = sphase_q + {steer_offs_q, 16'd0};
        mul_req.a = {9'd0, drive_amp_q};
        mul_req.b = {2'd0, sine.mag};
      end
      dstdm_pkg::ST_TD: begin
        rom_phase = sphase_q + {steer_offs_q, 16'd0};
        mul_req.a = {9'd0, steer_amp_q};
        mul_req.b = {2'd0, sine.mag};
      end
      dstdm_pkg::ST_TS: begin
        mul_req.a = {{8{td_q[TW-1]}}, td_q};
        mul_req.b = {1'b0, drive_gear_q};
      end
      dstdm_pkg::ST_PD, dstdm_pkg::ST_MIX: begin
        mul_req.a = {{8{ts_q[TW-1]}}, ts_q};
        mul_req.b = {1'b0, steer_gear_q};
      end
      default: begin
        mul_req   = '0;
        rom_phase = dphase_q;
      end
    endcase
  end

  assign rnd_sum = prod[29:0] + 30'd8192;
  assign tgt_mag = rnd_sum[29:14];
  assign tgt_pos = {1'b0, tgt_mag};

  assign mix_sum = SUMW'(pd_q) + SUMW'(signed'(prod[PDW-1:0])) + SUMW'(2048);
  assign mix_dif = SUMW'(pd_q) - SUMW'(signed'(prod[PDW-1:0])) + SUMW'(2048);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dstdm_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      dphase_q     <= '0;
      sphase_q     <= '0;
      drive_freq_q <= dstdm_pkg::DRIVE_FREQ_RST;
      steer_freq_q <= dstdm_pkg::STEER_FREQ_RST;
      steer_offs_q <= dstdm_pkg::STEER_OFFS_RST;
      drive_amp_q  <= dstdm_pkg::DRIVE_AMP_RST;
      steer_amp_q  <= dstdm_pkg::STEER_AMP_RST;
      drive_gear_q <= dstdm_pkg::DRIVE_GEAR_RST;
      steer_gear_q <= dstdm_pkg::STEER_GEAR_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == dstdm_pkg::ST_SF) begin
        dphase_q <= dphase_q + prod[PW-1:0];
      end
      if (state_q == dstdm_pkg::ST_SD) begin
        sphase_q <= sphase_q + prod[PW-1:0];
      end
      if (cfg_wr_en_i) begin
        unique case (dstdm_pkg::cfg_reg_e'(cfg_index_i))
          dstdm_pkg::REG_DRIVE_FREQ: drive_freq_q <= cfg_data_i;
          dstdm_pkg::REG_STEER_FREQ: steer_freq_q <= cfg_data_i;
          dstdm_pkg::REG_STEER_OFFS: steer_offs_q <= cfg_data_i[dstdm_pkg::OFFS_W-1:0];
          dstdm_pkg::REG_DRIVE_AMP:  drive_amp_q  <= cfg_data_i[GW-1:0];
          dstdm_pkg::REG_STEER_AMP:  steer_amp_q  <= cfg_data_i[GW-1:0];
          dstdm_pkg::REG_DRIVE_GEAR: drive_gear_q <= cfg_data_i[GW-1:0];
          dstdm_pkg::REG_STEER_GEAR: steer_gear_q <= cfg_data_i[GW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q <= time_step_i;
    end
    if (state_q == dstdm_pkg::ST_SS) begin
      dneg_q <= sine.neg;
    end
    if (state_q == dstdm_pkg::ST_TD) begin
      td_q <= dneg_q ? -tgt_pos : tgt_pos;
    end
    if (state_q == dstdm_pkg::ST_TS) begin
      ts_q <= sine.neg ? -tgt_pos : tgt_pos;
    end
    if (state_q == dstdm_pkg::ST_PD) begin
      pd_q <= prod[PDW-1:0];
    end
    if (out_load) begin
      drive_tgt_q <= td_q;
      steer_tgt_q <= ts_q;
      m0_q        <= mix_sum[dstdm_pkg::MOTOR_W+11:12];
      m1_q        <= mix_dif[dstdm_pkg::MOTOR_W+11:12];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_target_o    = drive_tgt_q;
  assign steer_target_o    = steer_tgt_q;
  assign motor0_position_o = m0_q;
  assign motor1_position_o = m1_q;

  `DSTDM_ASSERT(a_accept_starts, in_acc |=> state_q == dstdm_pkg::ST_DF)
  `DSTDM_ASSERT(a_result_from_mix, $rose(out_valid_q) |-> $past(state_q) == dstdm_pkg::ST_MIX)
  `DSTDM_ASSERT(a_mix_holds, (state_q == dstdm_pkg::ST_MIX && out_valid_q && !out_ready_i) |=> state_q == dstdm_pkg::ST_MIX)
  `DSTDM_NEVER(a_busy_not_ready, in_ready_o && state_q != dstdm_pkg::ST_IDLE)

endmodule

/* bench/dual_sine_trajectory_diff_mixer_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for dual_sine_trajectory_diff_mixer_core: random ticks and
// register settings under random flow control, checked against a built-in
// trajectory predictor. Depends on dstdm_pkg and the core RTL.
module dual_sine_trajectory_diff_mixer_core_test;

  localparam int unsigned HALF_CLK = 6;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned TICKS_PER_PHASE = 330;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam logic [dstdm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic signed [dstdm_pkg::TGT_W-1:0]   drive_target;
    logic signed [dstdm_pkg::TGT_W-1:0]   steer_target;
    logic signed [dstdm_pkg::MOTOR_W-1:0] motor0;
    logic signed [dstdm_pkg::MOTOR_W-1:0] motor1;
  } setpoint_t;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic [dstdm_pkg::STEP_W-1:0]          time_step = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic signed [dstdm_pkg::TGT_W-1:0]    drive_target;
  logic signed [dstdm_pkg::TGT_W-1:0]    steer_target;
  logic signed [dstdm_pkg::MOTOR_W-1:0]  motor0_position;
  logic signed [dstdm_pkg::MOTOR_W-1:0]  motor1_position;
  logic                                  cfg_wr_en = 1'b0;
  logic [dstdm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [dstdm_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  int unsigned quarter_sine [0:dstdm_pkg::QUARTER_N];
  logic [dstdm_pkg::FREQ_W-1:0]  drive_freq = dstdm_pkg::DRIVE_FREQ_RST;
  logic [dstdm_pkg::FREQ_W-1:0]  steer_freq = dstdm_pkg::STEER_FREQ_RST;
  logic [dstdm_pkg::OFFS_W-1:0]  steer_offs = dstdm_pkg::STEER_OFFS_RST;
  logic [dstdm_pkg::GAIN_W-1:0]  drive_amp = dstdm_pkg::DRIVE_AMP_RST;
  logic [dstdm_pkg::GAIN_W-1:0]  steer_amp = dstdm_pkg::STEER_AMP_RST;
  logic [dstdm_pkg::GAIN_W-1:0]  drive_gear = dstdm_pkg::DRIVE_GEAR_RST;
  logic [dstdm_pkg::GAIN_W-1:0]  steer_gear = dstdm_pkg::STEER_GEAR_RST;
  logic [dstdm_pkg::PHASE_W-1:0] drive_phase = '0;
  logic [dstdm_pkg::PHASE_W-1:0] steer_phase = '0;

  logic [dstdm_pkg::STEP_W-1:0] ticks_to_send [$];
  setpoint_t         expected_setpoints [$];
  int unsigned       ticks_queued = 0;
  int unsigned       ticks_taken = 0;
  int unsigned       words_checked = 0;
  int unsigned       settings_loaded = 0;
  int unsigned       mismatches = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       tick_gap = 0;
  int unsigned       ready_hold = 0;
  logic              tick_taken = 1'b0;
  logic              calm = 1'b0;

  dual_sine_trajectory_diff_mixer_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .time_step_i       (time_step),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .drive_target_o    (drive_target),
    .steer_target_o    (steer_target),
    .motor0_position_o (motor0_position),
    .motor1_position_o (motor1_position),
    .cfg_wr_en_i       (cfg_wr_en),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  always #(HALF_CLK) clk_i = ~clk_i;

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic int sine_q14(input logic [dstdm_pkg::PHASE_W-1:0] ph);
    logic [dstdm_pkg::SINE_TABLE_BITS-1:0] idx;
    int unsigned j;
    int unsigned mag;
    idx = ph[dstdm_pkg::PHASE_W-1 -: dstdm_pkg::SINE_TABLE_BITS];
    j   = 32'(idx[dstdm_pkg::SINE_TABLE_BITS-3:0]);
    mag = idx[dstdm_pkg::SINE_TABLE_BITS-2] ? quarter_sine[dstdm_pkg::QUARTER_N - j]
                                            : quarter_sine[j];
    return idx[dstdm_pkg::SINE_TABLE_BITS-1] ? -int'(mag) : int'(mag);
  endfunction

  function automatic longint scaled_target(input logic [dstdm_pkg::GAIN_W-1:0] amp,
                                           input int s);
    longint m;
    m = (longint'(amp) * longint'(s < 0 ? -s : s) + 64'sd8192) >>> 14;
    return s < 0 ? -m : m;
  endfunction

  task automatic advance_trajectory(input logic [dstdm_pkg::STEP_W-1:0] dt);
    longint    td;
    longint    ts;
    longint    pd;
    longint    ps;
    setpoint_t sp;
    drive_phase = drive_phase + dstdm_pkg::PHASE_W'(64'(drive_freq) * 64'(dt));
    steer_phase = steer_phase + dstdm_pkg::PHASE_W'(64'(steer_freq) * 64'(dt));
    td = scaled_target(drive_amp, sine_q14(drive_phase));
    ts = scaled_target(steer_amp, sine_q14(steer_phase + {steer_offs, 16'd0}));
    pd = td * longint'(drive_gear);
    ps = ts * longint'(steer_gear);
    sp.drive_target = dstdm_pkg::TGT_W'(td);
    sp.steer_target = dstdm_pkg::TGT_W'(ts);
    sp.motor0       = dstdm_pkg::MOTOR_W'((pd + ps + 64'sd2048) >>> 12);
    sp.motor1       = dstdm_pkg::MOTOR_W'((pd - ps + 64'sd2048) >>> 12);
    expected_setpoints.push_back(sp);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : setpoint_check
    setpoint_t want;
    if (out_valid && out_ready) begin
      if (expected_setpoints.size() == 0) begin
        $display("%0t ns: setpoint word with none expected", $time);
        mismatches++;
      end else begin
        want = expected_setpoints.pop_front();
        check_field("drive_target", want.drive_target, drive_target);
        check_field("steer_target", want.steer_target, steer_target);
        check_field("motor0_position", want.motor0, motor0_position);
        check_field("motor1_position", want.motor1, motor1_position);
        words_checked++;
      end
    end
    if (in_valid && in_ready) begin
      advance_trajectory(time_step);
      ticks_taken++;
    end
    tick_taken <= in_valid && in_ready;
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tick_taken) begin
      if (tick_gap != 0) begin
        in_valid <= 1'b0;
        tick_gap <= tick_gap - 1;
      end else if (ticks_to_send.size() != 0) begin
        in_valid  <= 1'b1;
        time_step <= ticks_to_send.pop_front();
        tick_gap  <= calm ? 0 : idle_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        ready_hold <= idle_length();
      end
    end
  end

  task automatic write_reg(input logic [dstdm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dstdm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_wr_en <= 1'b0;
    case (idx)
      dstdm_pkg::REG_DRIVE_FREQ: drive_freq = val;
      dstdm_pkg::REG_STEER_FREQ: steer_freq = val;
      dstdm_pkg::REG_STEER_OFFS: steer_offs = val[dstdm_pkg::OFFS_W-1:0];
      dstdm_pkg::REG_DRIVE_AMP:  drive_amp  = val[dstdm_pkg::GAIN_W-1:0];
      dstdm_pkg::REG_STEER_AMP:  steer_amp  = val[dstdm_pkg::GAIN_W-1:0];
      dstdm_pkg::REG_DRIVE_GEAR: drive_gear = val[dstdm_pkg::GAIN_W-1:0];
      dstdm_pkg::REG_STEER_GEAR: steer_gear = val[dstdm_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [dstdm_pkg::CFG_DATA_W-1:0] d_freq, s_freq, offs,
                              input logic [dstdm_pkg::CFG_DATA_W-1:0] d_amp, s_amp,
                              input logic [dstdm_pkg::CFG_DATA_W-1:0] d_gear, s_gear);
    write_reg(dstdm_pkg::REG_DRIVE_FREQ, d_freq);
    write_reg(dstdm_pkg::REG_STEER_FREQ, s_freq);
    write_reg(dstdm_pkg::REG_STEER_OFFS, offs);
    write_reg(dstdm_pkg::REG_DRIVE_AMP, d_amp);
    write_reg(dstdm_pkg::REG_STEER_AMP, s_amp);
    write_reg(dstdm_pkg::REG_DRIVE_GEAR, d_gear);
    write_reg(dstdm_pkg::REG_STEER_GEAR, s_gear);
    settings_loaded++;
  endtask

  function automatic logic [dstdm_pkg::CFG_DATA_W-1:0] random_word();
    return dstdm_pkg::CFG_DATA_W'($urandom);
  endfunction

  function automatic logic [dstdm_pkg::CFG_DATA_W-1:0] random_freq();
    case ($urandom_range(0, 3))
      0:       return dstdm_pkg::CFG_DATA_W'($urandom_range(0, 255));
      1:       return dstdm_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      default: return random_word();
    endcase
  endfunction

  task automatic queue_tick(input logic [dstdm_pkg::STEP_W-1:0] dt);
    ticks_to_send.push_back(dt);
    ticks_queued++;
  endtask

  task automatic drain();
    while (ticks_taken != ticks_queued || expected_setpoints.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin : stimulus
    int unsigned     k;
    int unsigned     n;
    int unsigned     p;
    int unsigned     r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;

    for (k = 0; k <= dstdm_pkg::QUARTER_N; k++) begin
      x    = (64'(k) * dstdm_pkg::HALF_PI_Q30) / dstdm_pkg::QUARTER_N;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / (4 * n * n + 2 * n);
        sum  = n[0] ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      q = (longint'(sum) + 64'sd32768) >>> 16;
      quarter_sine[k] = (q > 16384) ? 16384 : 32'(q);
    end

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults
    settings_loaded = 1;
    queue_tick(16'h0000); queue_tick(16'hFFFF); queue_tick(16'h0001);
    queue_tick(16'h0002); queue_tick(16'h8000); queue_tick(16'h5555);
    queue_tick(16'hAAAA); queue_tick(16'h00FF); queue_tick(16'hFF00);
    drain();

    // everything at full scale, upper data bits dropped by narrow registers
    load_setting('1, '1, '1, '1, '1, '1, '1);
    write_reg(REG_UNMAPPED, '0);
    queue_tick(16'h0000); queue_tick(16'h0001); queue_tick(16'hFFFF);
    queue_tick(16'h4000); queue_tick(16'h1234);
    drain();

    load_setting('0, '0, '0, '0, '0, '0, '0);
    queue_tick(16'hFFFF); queue_tick(16'h0000); queue_tick(16'h7FFF);
    drain();

    // zero frequencies freeze the phases; steer offset a quarter turn, then three quarters
    load_setting('0, '0, 24'h004000, '1, '1, '1, '1);
    queue_tick(16'hFFFF); queue_tick(16'h0000);
    drain();
    write_reg(dstdm_pkg::REG_STEER_OFFS, 24'h00C000);
    write_reg(dstdm_pkg::REG_DRIVE_FREQ, 24'h000001);
    queue_tick(16'h4000); queue_tick(16'h8000);
    drain();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      load_setting(random_freq(), random_freq(), random_word(), random_word(),
                   random_word(), random_word(), random_word());
      for (k = 0; k < TICKS_PER_PHASE; k++) begin
        r = $urandom_range(0, 9);
        if (r < 6)       queue_tick(dstdm_pkg::STEP_W'($urandom));
        else if (r < 8)  queue_tick(dstdm_pkg::STEP_W'($urandom_range(0, 255)));
        else if (r == 8) queue_tick('0);
        else             queue_tick('1);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_setpoints.size() != 0) begin
      $display("%0t ns: %0d setpoint words never arrived", $time, expected_setpoints.size());
      mismatches++;
    end
    $display("Drove %0d ticks over %0d register settings with random gaps and stalls;",
             ticks_taken, settings_loaded);
    $display("checked %0d setpoint words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dstdm_pkg.sv
rtl/core/dstdm_mul.sv
rtl/core/dstdm_sine_rom.sv
rtl/core/dual_sine_trajectory_diff_mixer_core.sv
bench/dual_sine_trajectory_diff_mixer_core_test.sv
